// ===== hdl/sha_pkg.sv =====
// shared types, constants and round-constant lookup for the sha-256 hasher
// no dependencies
package sha_pkg;

   localparam int unsigned WordCount = 8;
   localparam logic [7:0]  PadByte   = 8'h80;
   localparam logic [5:0]  LenPos    = 6'd56;
   localparam logic [5:0]  LastPos   = 6'd63;
   localparam logic [5:0]  PreLenPos = 6'd55;

   typedef enum logic [1:0] {
      SEL_DATA  = 2'd0,
      SEL_PAD80 = 2'd1,
      SEL_ZERO  = 2'd2,
      SEL_LEN   = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic         write_en;
      byte_sel_type byte_sel;
      logic         count_en;
      logic         len_load;
      logic         len_shift;
      logic         init_work;
      logic         round_en;
      logic [5:0]   rnd;
      logic         add_hash;
      logic         clear_msg;
      logic [2:0]   out_idx;
   } dp_cmd_type;

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] v;
      unique case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         3'd7: v = 32'h5be0cd19;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] v;
      unique case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/sha_if.sv =====
// valid/ready channel interfaces for message bytes and digest words
// no dependencies
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;
   logic       no_byte;
   modport source (output valid, data_byte, is_last, no_byte, input ready);
   modport sink   (input valid, data_byte, is_last, no_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;
   modport source (output valid, digest_word, word_number, last_word, input ready);
   modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== hdl/sha_ctrl.sv =====
// sequencer for byte loading, padding, compression rounds and digest output
// depends on sha_pkg
module sha_ctrl
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       in_last,
   input  logic       in_no_byte,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_FINAL = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] oidx_ff, oidx_in;
   logic       pad_ff, pad_in;
   logic       sent80_ff, sent80_in;
   logic       lenok_ff, lenok_in;
   logic       pend_ff, pend_in;
   logic       final_ff, final_in;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      rnd_in    = rnd_ff;
      oidx_in   = oidx_ff;
      pad_in    = pad_ff;
      sent80_in = sent80_ff;
      lenok_in  = lenok_ff;
      pend_in   = pend_ff;
      final_in  = final_ff;
      cmd       = '0;
      cmd.byte_sel = SEL_DATA;
      cmd.rnd     = rnd_ff;
      cmd.out_idx = oidx_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (!in_no_byte) begin
                  cmd.write_en = 1'b1;
                  cmd.count_en = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == LastPos) begin
                     cmd.init_work = 1'b1;
                     pend_in  = in_last;
                     rnd_in   = '0;
                     state_in = ST_ROUND;
                  end else if (in_last) begin
                     pad_in   = 1'b1;
                     state_in = ST_PAD;
                  end
               end else if (in_last) begin
                  pad_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.write_en = 1'b1;
            cmd.len_load = !sent80_ff;
            if (!sent80_ff) begin
               cmd.byte_sel = SEL_PAD80;
               sent80_in = 1'b1;
            end else if (lenok_ff && fill_ff >= LenPos) begin
               cmd.byte_sel  = SEL_LEN;
               cmd.len_shift = 1'b1;
            end else begin
               cmd.byte_sel = SEL_ZERO;
            end
            // the length fits once a pad byte lands just ahead of its field
            if (cmd.byte_sel != SEL_LEN && fill_ff == PreLenPos) lenok_in = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == LastPos) begin
               cmd.init_work = 1'b1;
               final_in = (cmd.byte_sel == SEL_LEN);
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LastPos) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.add_hash = 1'b1;
            if (final_ff) begin
               oidx_in  = '0;
               state_in = ST_OUT;
            end else if (pend_ff) begin
               pend_in  = 1'b0;
               pad_in   = 1'b1;
               state_in = ST_PAD;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'(WordCount - 1)) begin
                  cmd.clear_msg = 1'b1;
                  fill_in   = '0;
                  pad_in    = 1'b0;
                  sent80_in = 1'b0;
                  lenok_in  = 1'b0;
                  final_in  = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
         pad_ff    <= 1'b0;
         sent80_ff <= 1'b0;
         lenok_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         rnd_ff    <= rnd_in;
         oidx_ff   <= oidx_in;
         pad_ff    <= pad_in;
         sent80_ff <= sent80_in;
         lenok_ff  <= lenok_in;
         pend_ff   <= pend_in;
         final_ff  <= final_in;
      end
   end

endmodule

// ===== hdl/sha_datapath.sv =====
// block window, message schedule, round unit, hash words and length counter
// depends on sha_pkg
module sha_datapath
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [7:0]  in_byte,
   output logic [31:0] digest_word
);

   logic [511:0] window_ff, window_in;
   logic [31:0]  hash_ff [WordCount];
   logic [31:0]  work_ff [WordCount];
   logic [60:0]  count_ff;
   logic [63:0]  len_ff;
   logic [7:0]   wr_byte;

   logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
   logic [31:0] sig0, sig1, ch, maj, t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      unique case (cmd.byte_sel)
         SEL_DATA:  wr_byte = in_byte;
         SEL_PAD80: wr_byte = PadByte;
         SEL_ZERO:  wr_byte = 8'h00;
         SEL_LEN:   wr_byte = len_ff[63:56];
         default:   wr_byte = 8'h00;
      endcase
   end

   // schedule taps: w[t-16], w[t-15], w[t-7], w[t-2]
   assign w0    = window_ff[511:480];
   assign w1    = window_ff[479:448];
   assign w9    = window_ff[223:192];
   assign w14   = window_ff[63:32];
   assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
   assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
   assign w_new = w0 + s0 + w9 + s1;

   assign sig1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign t1   = work_ff[7] + sig1 + ch + round_k(cmd.rnd) + w0;
   assign sig0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                 (work_ff[1] & work_ff[2]);
   assign t2   = sig0 + maj;

   always_comb begin
      window_in = window_ff;
      if (cmd.write_en)      window_in = {window_ff[503:0], wr_byte};
      else if (cmd.round_en) window_in = {window_ff[479:0], w_new};
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (cmd.len_load)       len_ff <= {count_ff, 3'b000};
      else if (cmd.len_shift) len_ff <= {len_ff[55:0], 8'h00};
      if (cmd.init_work) begin
         for (int i = 0; i < WordCount; i++) work_ff[i] <= hash_ff[i];
      end else if (cmd.round_en) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_msg) begin
         for (int i = 0; i < WordCount; i++) hash_ff[i] <= init_hash(3'(i));
         count_ff <= '0;
      end else begin
         if (cmd.add_hash) begin
            for (int i = 0; i < WordCount; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
         if (cmd.count_en) count_ff <= count_ff + 61'd1;
      end
   end

   assign digest_word = hash_ff[cmd.out_idx];

endmodule

// ===== hdl/sha256_byte_stream_hasher_top.sv =====
// sha-256 over a byte stream: at most one message byte per item, eight digest words out
// an item is taken only while idle; each full 64-byte block then runs
// 64 rounds on the single round unit, then one hash update
// a last item adds 1-2 padding blocks (pad bytes to the block end), then 8 words
// synchronous active-high reset loads the initial hash and clears the byte count
// depends on sha_pkg, sha_if, sha_ctrl and sha_datapath
module sha256_byte_stream_hasher_top
   import sha_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sha_req_if.sink   req_ch,
   sha_rsp_if.source rsp_ch
);

   dp_cmd_type cmd;
   logic [31:0] digest_word;

   // sequencer: takes items only between blocks, steps rounds and padding
   sha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_last    (req_ch.is_last),
      .in_no_byte (req_ch.no_byte),
      .in_ready   (req_ch.ready),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   // datapath: 512-bit window doubles as block buffer and schedule shift line
   sha_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_ch.data_byte),
      .digest_word (digest_word)
   );

   // digest words come straight from the hash registers, held while stalled
   assign rsp_ch.digest_word = digest_word;
   assign rsp_ch.word_number = cmd.out_idx;
   assign rsp_ch.last_word   = (cmd.out_idx == 3'(WordCount - 1));

endmodule
